[src/distance_vector_route_update_assert.svh]
// ----------------------------------------------------------------------------
// distance vector route update assertion macros
// shared helpers for concurrent checks, clocked on clk_i, idle in reset
// ----------------------------------------------------------------------------
`ifndef DISTANCE_VECTOR_ROUTE_UPDATE_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTE_UPDATE_ASSERT_SVH

// plain property under clock and reset
`define DVR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define DVR_ASSERT_IMPL(lbl, ante, cons, msg) \
  `DVR_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[src/dvr_pkg.sv]
// ----------------------------------------------------------------------------
// dvr_pkg
// types and constants of the distance vector route update block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dvr_pkg;

  localparam int unsigned COST_W  = 31;
  localparam int unsigned LABEL_W = 8;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned SEL_W   = 3;
  localparam int unsigned IDX_EXT_W = 9;

  localparam logic [COST_W-1:0] COST_INF      = {COST_W{1'b1}};
  localparam logic [PORT_W-1:0] PORT_BASE_RST = 16'd10000;

  // configuration register indexes
  localparam logic CFG_OWN_INDEX = 1'b0;
  localparam logic CFG_PORT_BASE = 1'b1;

  // request kinds
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_ADVERT = 1'b1;

  typedef struct packed {
    logic [PORT_W-1:0]  dest_port;
    logic [PORT_W-1:0]  out_port;
    logic [LABEL_W-1:0] label;
    logic [COST_W-1:0]  cost;
  } entry_t;

  localparam entry_t ENTRY_RST = '{
    dest_port: '0,
    out_port:  '0,
    label:     '0,
    cost:      COST_INF
  };

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

endpackage

[src/distance_vector_route_update.sv]
// ----------------------------------------------------------------------------
// distance vector route update
// routing table with direct entry writes and bellman-ford relaxation
// ----------------------------------------------------------------------------
// Input beats on the s_axis channel either load one table entry (tuser = 0)
// or carry one entry of a neighbour's distance vector (tuser = 1), which is
// relaxed through our link to that neighbour. tlast marks the end of a
// vector. Every input beat gives exactly one result beat on m_axis with the
// entry as it stands after the beat, plus entry and vector change flags.
// The table sits in one memory with two read ports and one write port. A
// beat is taken in the idle state and both entries are read; in the execute
// state the add-compare runs and, once the output register is free, the
// entry is written back and the result is loaded. No new beat is taken
// before the last one has left execute. When the receiver stalls, a finished
// result waits in the output register and one more beat is taken and held in
// the execute state until it drains. Reset clears the per-entry valid bits
// at once, so every entry reads as infinite cost with zero label and ports;
// no clearing pass is needed. Configuration (own index, port base) is
// written by the user through cfg_* while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module distance_vector_route_update
  import dvr_pkg::*;
#(
  parameter int unsigned NODES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // sender, entry_index, cost, label, dest_port, out_port
  input  logic [79:0] s_axis_tdata_i,
  // req_type
  input  logic [0:0]  s_axis_tuser_i,
  input  logic        s_axis_tlast_i,
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // result_index, result_cost, result_label, result_out_port, result_dest_port
  output logic [79:0] m_axis_tdata_o,
  // entry_changed, vector_changed
  output logic [1:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  localparam int unsigned AW = $clog2(NODES);

  // configuration
  logic [SEL_W-1:0]  own_index_q;
  logic [PORT_W-1:0] port_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_index_q <= '0;
      port_base_q <= PORT_BASE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OWN_INDEX: own_index_q <= cfg_wdata_i[SEL_W-1:0];
        CFG_PORT_BASE: port_base_q <= cfg_wdata_i[PORT_W-1:0];
        default: ;
      endcase
    end
  end

  // input unpacking
  logic               in_type;
  logic [SEL_W-1:0]   in_snd;
  logic [SEL_W-1:0]   in_idx;
  logic [COST_W-1:0]  in_cost;
  logic [LABEL_W-1:0] in_label;
  logic [PORT_W-1:0]  in_dpt;
  logic [PORT_W-1:0]  in_opt;
  logic [IDX_EXT_W-1:0] idx_ext;
  logic [IDX_EXT_W-1:0] snd_ext;
  logic [AW-1:0]      idx_addr;
  logic [AW-1:0]      snd_addr;

  assign in_type  = s_axis_tuser_i[0];
  assign in_snd   = s_axis_tdata_i[2:0];
  assign in_idx   = s_axis_tdata_i[5:3];
  assign in_cost  = s_axis_tdata_i[36:6];
  assign in_label = s_axis_tdata_i[44:37];
  assign in_dpt   = s_axis_tdata_i[60:45];
  assign in_opt   = s_axis_tdata_i[76:61];
  assign idx_ext  = {{(IDX_EXT_W-SEL_W){1'b0}}, in_idx};
  assign snd_ext  = {{(IDX_EXT_W-SEL_W){1'b0}}, in_snd};
  assign idx_addr = idx_ext[AW-1:0];
  assign snd_addr = snd_ext[AW-1:0];

  // control
  state_e state_q, state_d;
  logic   accept;
  logic   out_free;
  logic   done;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept   = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free = ~m_axis_tvalid_o | m_axis_tready_i;
  assign done     = (state_q == ST_EXEC) & out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_EXEC;
      ST_EXEC: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // held request
  logic               type_q;
  logic [SEL_W-1:0]   snd_q;
  logic [SEL_W-1:0]   idx_q;
  logic [AW-1:0]      addr_q;
  logic [COST_W-1:0]  cost_q;
  logic [LABEL_W-1:0] label_q;
  logic [PORT_W-1:0]  dpt_q;
  logic [PORT_W-1:0]  opt_q;
  logic               last_q;
  logic               idx_ok_q;
  logic               snd_ok_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      type_q   <= in_type;
      snd_q    <= in_snd;
      idx_q    <= in_idx;
      addr_q   <= idx_addr;
      cost_q   <= in_cost;
      label_q  <= in_label;
      dpt_q    <= in_dpt;
      opt_q    <= in_opt;
      last_q   <= s_axis_tlast_i;
      idx_ok_q <= (idx_ext < IDX_EXT_W'(NODES));
      snd_ok_q <= (snd_ext < IDX_EXT_W'(NODES));
    end
  end

  // route table memory with per-entry valid bits
  entry_t           mem [NODES];
  logic [NODES-1:0] vld_q;
  entry_t           rd_ent_q;
  entry_t           rd_lnk_q;
  logic             ent_vld_q;
  logic             lnk_vld_q;
  logic             mem_we;
  entry_t           wr_ent;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr_q] <= wr_ent;
    end
    if (accept) begin
      rd_ent_q <= mem[idx_addr];
      rd_lnk_q <= mem[snd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      ent_vld_q <= 1'b0;
      lnk_vld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[addr_q] <= 1'b1;
      end
      if (accept) begin
        ent_vld_q <= vld_q[idx_addr];
        lnk_vld_q <= vld_q[snd_addr];
      end
    end
  end

  // relaxation
  entry_t            cur_ent;
  logic [COST_W-1:0] link_cost;
  logic [COST_W:0]   sum_raw;
  logic [COST_W-1:0] sum_sat;
  logic              relax;
  entry_t            new_ent;
  entry_t            res_ent;
  logic              any_chg_q;
  logic              vec_chg;

  assign cur_ent   = ent_vld_q ? rd_ent_q : ENTRY_RST;
  assign link_cost = (lnk_vld_q && snd_ok_q) ? rd_lnk_q.cost : COST_INF;
  assign sum_raw   = {1'b0, cost_q} + {1'b0, link_cost};
  assign sum_sat   = (sum_raw >= {1'b0, COST_INF}) ? COST_INF : sum_raw[COST_W-1:0];
  assign relax     = (type_q == REQ_ADVERT) && idx_ok_q && (idx_q != own_index_q) &&
                     (cost_q != COST_INF) && (link_cost != COST_INF) &&
                     (cur_ent.cost > sum_sat);

  always_comb begin
    new_ent = cur_ent;
    if (type_q == REQ_WRITE) begin
      new_ent.cost      = cost_q;
      new_ent.label     = label_q;
      new_ent.out_port  = opt_q;
      new_ent.dest_port = dpt_q;
    end else if (relax) begin
      new_ent.cost      = sum_sat;
      new_ent.label     = label_q;
      new_ent.out_port  = port_base_q + {{(PORT_W-SEL_W){1'b0}}, snd_q};
      new_ent.dest_port = dpt_q;
    end
  end

  assign wr_ent  = new_ent;
  assign mem_we  = done && idx_ok_q && ((type_q == REQ_WRITE) || relax);
  assign res_ent = idx_ok_q ? new_ent : ENTRY_RST;
  assign vec_chg = (type_q == REQ_ADVERT) && last_q && (any_chg_q || relax);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_chg_q <= 1'b0;
    end else if (done && (type_q == REQ_ADVERT)) begin
      any_chg_q <= last_q ? 1'b0 : (any_chg_q | relax);
    end
  end

  // output register
  logic        m_valid_q;
  logic [79:0] m_data_q;
  logic [1:0]  m_user_q;
  logic        m_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (done) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      m_data_q <= {6'b0, res_ent.dest_port, res_ent.out_port, res_ent.label,
                   res_ent.cost, idx_q};
      m_user_q <= {vec_chg, relax};
      m_last_q <= last_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

  // checks
`include "distance_vector_route_update_assert.svh"

  `DVR_ASSERT(a_accept_to_exec, accept |=> (state_q == ST_EXEC), "accepted beat not executed")
  `DVR_ASSERT_IMPL(a_write_in_exec, mem_we, (state_q == ST_EXEC) && out_free, "table written outside execute")
  `DVR_ASSERT_IMPL(a_change_finite, m_axis_tvalid_o && m_axis_tuser_o[0], m_axis_tdata_o[33:3] != COST_INF, "improved entry left infinite")
  `DVR_ASSERT_IMPL(a_vec_on_last, m_axis_tvalid_o && m_axis_tuser_o[1], m_axis_tlast_o, "vector change flag without last")

endmodule

[dv/distance_vector_route_update_tb.sv]
// ----------------------------------------------------------------------------
// distance vector route update testbench
// drives entry writes and neighbour vectors into the route table, keeps its
// own copy of the table and checks every result beat field by field, with
// the sender and the receiver idling at random, in turn and together
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module distance_vector_route_update_tb;
  import dvr_pkg::*;

  localparam int unsigned NODES = 8;

  typedef struct {
    logic               req_type;
    logic [SEL_W-1:0]   sender;
    logic [SEL_W-1:0]   entry_index;
    logic [COST_W-1:0]  cost;
    logic [LABEL_W-1:0] label;
    logic [PORT_W-1:0]  dest_port;
    logic [PORT_W-1:0]  out_port;
    logic               last;
  } route_req_t;

  typedef struct {
    logic [SEL_W-1:0] index;
    entry_t           entry;
    logic             entry_changed;
    logic             vector_changed;
    logic             last;
  } route_report_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic        cfg_idx_i       = CFG_OWN_INDEX;
  logic [15:0] cfg_wdata_i     = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [79:0] s_axis_tdata_i  = '0;
  logic [0:0]  s_axis_tuser_i  = REQ_WRITE;
  logic        s_axis_tlast_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [79:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  // predictor state
  entry_t           route_table [NODES];
  logic             change_pending = 1'b0;
  logic [SEL_W-1:0] own_index      = '0;
  logic [PORT_W-1:0] port_base     = PORT_BASE_RST;

  route_report_t expected_reports [$];
  int unsigned   mismatches = 0;
  int unsigned   idle_pct   = 0;
  int unsigned   stall_pct  = 0;

  distance_vector_route_update #(
    .NODES(NODES)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    for (int k = 0; k < NODES; k++) route_table[k] = ENTRY_RST;
  end

  // one beat against the table copy: a direct write or a bellman-ford relaxation
  function automatic route_report_t relax_entry(input route_req_t r);
    route_report_t rep;
    logic [COST_W:0] sum;
    logic improved;
    improved = 1'b0;
    rep.vector_changed = 1'b0;
    if (r.req_type == REQ_WRITE) begin
      route_table[r.entry_index] = '{dest_port: r.dest_port, out_port: r.out_port,
                                     label: r.label, cost: r.cost};
    end else begin
      if (r.entry_index != own_index && r.cost != COST_INF &&
          route_table[r.sender].cost != COST_INF) begin
        sum = {1'b0, r.cost} + {1'b0, route_table[r.sender].cost};
        if (sum >= {1'b0, COST_INF}) sum = {1'b0, COST_INF};
        if (route_table[r.entry_index].cost > sum[COST_W-1:0]) begin
          route_table[r.entry_index] = '{dest_port: r.dest_port,
                                         out_port: port_base + 16'(r.sender),
                                         label: r.label, cost: sum[COST_W-1:0]};
          improved = 1'b1;
        end
      end
      if (r.last) begin
        rep.vector_changed = change_pending | improved;
        change_pending = 1'b0;
      end else begin
        change_pending = change_pending | improved;
      end
    end
    rep.index = r.entry_index;
    rep.entry = route_table[r.entry_index];
    rep.entry_changed = improved;
    rep.last = r.last;
    return rep;
  endfunction

  function automatic route_req_t make_req(input logic kind, input logic [2:0] snd,
                                          input logic [2:0] idx, input logic [30:0] cst,
                                          input logic [7:0] lbl, input logic [15:0] dpt,
                                          input logic [15:0] opt, input logic lst);
    route_req_t r;
    r = '{req_type: kind, sender: snd, entry_index: idx, cost: cst, label: lbl,
          dest_port: dpt, out_port: opt, last: lst};
    return r;
  endfunction

  function automatic logic [COST_W-1:0] rand_cost();
    case ($urandom_range(9))
      0:       return COST_INF;
      1:       return COST_W'($urandom());
      2:       return COST_INF - COST_W'($urandom_range(3));
      default: return COST_W'($urandom_range(200));
    endcase
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h, got %0h at %0t", field, want, got, $realtime);
    end
  endfunction

  task automatic send_beat(input route_req_t r);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= r.req_type;
    s_axis_tlast_i  <= r.last;
    s_axis_tdata_i  <= {3'b0, r.out_port, r.dest_port, r.label, r.cost,
                        r.entry_index, r.sender};
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_reports.push_back(relax_entry(r));
  endtask

  task automatic finish_burst();
    s_axis_tvalid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_OWN_INDEX) own_index = value[SEL_W-1:0];
    else port_base = value;
  endtask

  // receiver side
  always @(posedge clk_i) m_axis_tready_i <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin : result_check
    route_report_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result beat with nothing expected at %0t", $realtime);
      end else begin
        want = expected_reports.pop_front();
        check_field("result_index", 32'(want.index), 32'(m_axis_tdata_o[2:0]));
        check_field("result_cost", 32'(want.entry.cost), 32'(m_axis_tdata_o[33:3]));
        check_field("result_label", 32'(want.entry.label), 32'(m_axis_tdata_o[41:34]));
        check_field("result_out_port", 32'(want.entry.out_port), 32'(m_axis_tdata_o[57:42]));
        check_field("result_dest_port", 32'(want.entry.dest_port),
                    32'(m_axis_tdata_o[73:58]));
        check_field("entry_changed", 32'(want.entry_changed), 32'(m_axis_tuser_o[0]));
        check_field("vector_changed", 32'(want.vector_changed), 32'(m_axis_tuser_o[1]));
        check_field("result_last", 32'(want.last), 32'(m_axis_tlast_o));
      end
    end
  end

  task automatic test_reset_state();
    // no link to sender 1 yet
    send_beat(make_req(REQ_ADVERT, 3'd1, 3'd3, 31'd1, 8'h10, 16'h0101, 16'h0, 1'b0));
    finish_burst();
  endtask

  task automatic test_direct_writes();
    send_beat(make_req(REQ_WRITE, 3'd0, 3'd1, 31'd5, 8'h41, 16'hFFFF, 16'h0000, 1'b0));
    send_beat(make_req(REQ_WRITE, 3'd7, 3'd2, COST_INF - 31'd1, 8'hFF, 16'h0000,
                       16'hFFFF, 1'b1));
    send_beat(make_req(REQ_WRITE, 3'd0, 3'd7, 31'd0, 8'h00, 16'h1234, 16'hABCD, 1'b0));
    send_beat(make_req(REQ_WRITE, 3'd0, 3'd6, COST_INF, 8'h5A, 16'h5555, 16'hAAAA, 1'b0));
    finish_burst();
  endtask

  task automatic test_relaxation();
    send_beat(make_req(REQ_ADVERT, 3'd1, 3'd4, 31'd10, 8'h11, 16'h2222, 16'h0, 1'b0));
    send_beat(make_req(REQ_ADVERT, 3'd1, 3'd4, 31'd20, 8'h12, 16'h3333, 16'h0, 1'b0));
    // own entry
    send_beat(make_req(REQ_ADVERT, 3'd1, 3'd0, 31'd0, 8'h13, 16'h4444, 16'h0, 1'b0));
    // unreachable advertised cost
    send_beat(make_req(REQ_ADVERT, 3'd1, 3'd5, COST_INF, 8'h14, 16'h5555, 16'h0, 1'b0));
    // unreachable link
    send_beat(make_req(REQ_ADVERT, 3'd3, 3'd6, 31'd1, 8'h15, 16'h6666, 16'h0, 1'b0));
    // sum saturates to infinite
    send_beat(make_req(REQ_ADVERT, 3'd2, 3'd6, 31'd1, 8'h16, 16'h7777, 16'h0, 1'b0));
    send_beat(make_req(REQ_ADVERT, 3'd2, 3'd6, 31'd0, 8'h17, 16'h8888, 16'hFFFF, 1'b0));
    send_beat(make_req(REQ_ADVERT, 3'd7, 3'd3, COST_INF - 31'd1, 8'h18, 16'hFFFF,
                       16'h0, 1'b0));
    send_beat(make_req(REQ_ADVERT, 3'd1, 3'd5, 31'd3, 8'h19, 16'h9999, 16'h0, 1'b1));
    finish_burst();
  endtask

  task automatic test_vector_end();
    send_beat(make_req(REQ_ADVERT, 3'd1, 3'd4, 31'd100, 8'h21, 16'h0, 16'h0, 1'b1));
    send_beat(make_req(REQ_ADVERT, 3'd7, 3'd2, 31'd1, 8'h22, 16'h0, 16'h0, 1'b0));
    // a write carrying last leaves the change flag alone
    send_beat(make_req(REQ_WRITE, 3'd0, 3'd2, 31'd9, 8'h23, 16'h0, 16'h0, 1'b1));
    send_beat(make_req(REQ_ADVERT, 3'd1, 3'd4, 31'd100, 8'h24, 16'h0, 16'h0, 1'b1));
    finish_burst();
  endtask

  task automatic test_port_wrap();
    write_register(CFG_OWN_INDEX, 16'd7);
    write_register(CFG_PORT_BASE, 16'hFFFF);
    send_beat(make_req(REQ_ADVERT, 3'd1, 3'd0, 31'd0, 8'h31, 16'hCAFE, 16'h0, 1'b0));
    send_beat(make_req(REQ_ADVERT, 3'd1, 3'd7, 31'd0, 8'h32, 16'h0, 16'h0, 1'b1));
    finish_burst();
  endtask

  task automatic test_random_traffic(input int unsigned beats, input logic [2:0] own,
                                     input logic [15:0] base, input int unsigned sidle,
                                     input int unsigned rstall);
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    logic [2:0]  snd;
    write_register(CFG_OWN_INDEX, 16'(own));
    write_register(CFG_PORT_BASE, base);
    idle_pct  = sidle;
    stall_pct = rstall;
    sent = 0;
    while (sent < beats) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        send_beat(make_req(REQ_WRITE, 3'($urandom()), 3'($urandom()), rand_cost(),
                           8'($urandom()), 16'($urandom()), 16'($urandom()),
                           1'($urandom())));
        sent++;
      end else if (pick < 30) begin
        send_beat(make_req(REQ_ADVERT, 3'($urandom()), 3'($urandom()), rand_cost(),
                           8'($urandom()), 16'($urandom()), 16'($urandom()),
                           1'($urandom())));
        sent++;
      end else begin
        snd = 3'($urandom());
        len = $urandom_range(1, NODES);
        for (int unsigned k = 0; k < len; k++) begin
          send_beat(make_req(REQ_ADVERT, snd, 3'($urandom()), rand_cost(),
                             8'($urandom()), 16'($urandom()), 16'($urandom()),
                             k == len - 1));
          sent++;
        end
      end
    end
    finish_burst();
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_direct_writes();
    test_relaxation();
    test_vector_end();
    test_port_wrap();
    test_random_traffic(150, 3'd0, 16'h0000, 0, 0);
    test_random_traffic(150, 3'd7, 16'hFFFF, 80, 0);
    test_random_traffic(150, 3'($urandom()), 16'($urandom()), 0, 80);
    test_random_traffic(150, 3'($urandom()), 16'($urandom()), 29, 29);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[distance_vector_route_update.f]
+incdir+src
src/dvr_pkg.sv
src/distance_vector_route_update.sv
dv/distance_vector_route_update_tb.sv
